### rtl/fst_pkg.sv
`timescale 1ns / 1ps

package fst_pkg;

    // Size of the control bank and the number of faders without an LED.
    localparam int NUM_CONTROLS = 16;
    localparam int NUM_FADERS   = 4;

    // Field widths of the request and result items.
    localparam int CTRL_W  = 4;
    localparam int VALUE_W = 7;
    localparam int KIND_W  = 2;
    localparam int LED_W   = 2;

    // Only indices that fit the control field can ever reach the table.
    localparam int TABLE_DEPTH = (NUM_CONTROLS < (1 << CTRL_W)) ? NUM_CONTROLS : (1 << CTRL_W);
    localparam int TAB_IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Reset value of the zero catch limit.
    localparam logic [VALUE_W-1:0] ZERO_CATCH_RESET = VALUE_W'(2);

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        REQ_POSITION = 2'd0,
        REQ_PICKUP   = 2'd1,
        REQ_ENABLE   = 2'd2,
        REQ_DISABLE  = 2'd3
    } req_kind_t;

    // LED colour actions.
    typedef enum logic [LED_W-1:0] {
        LED_NONE       = 2'd0,
        LED_LIT_GREEN  = 2'd1,
        LED_LIT_ORANGE = 2'd2,
        LED_OFF        = 2'd3
    } led_t;

    // A classified request as it travels from the front to the back.
    typedef struct packed {
        req_kind_t              kind;
        logic [CTRL_W-1:0]      ctrl;
        logic [TAB_IDX_W-1:0]   slot;
        logic                   ctrl_ok;
        logic                   has_led;
        logic [VALUE_W-1:0]     value;
    } cmd_t;

endpackage

### rtl/fst_front.sv
`timescale 1ns / 1ps

module fst_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fst_pkg::KIND_W-1:0]    req_type,
    input  logic [fst_pkg::CTRL_W-1:0]    control_index,
    input  logic [fst_pkg::VALUE_W-1:0]   value,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output fst_pkg::cmd_t                 cmd
);
    import fst_pkg::*;

    cmd_t        cmd_new;
    cmd_t        fifo_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    // Classify the incoming request: range check, LED ownership and table slot.
    always_comb
    begin
        cmd_new.kind     = req_kind_t'(req_type);
        cmd_new.ctrl     = control_index;
        cmd_new.slot     = control_index[TAB_IDX_W-1:0];
        cmd_new.ctrl_ok  = 32'(control_index) < NUM_CONTROLS;
        cmd_new.has_led  = 32'(control_index) >= NUM_FADERS;
        cmd_new.value    = value;
    end

    // Two-entry queue handshakes.
    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = fifo_reg[rd_ptr_reg];

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; payload only, so no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

### rtl/fst_back.sv
`timescale 1ns / 1ps

module fst_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  fst_pkg::cmd_t                 cmd,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fst_pkg::VALUE_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fst_pkg::CTRL_W-1:0]    control_out,
    output logic                          value_valid,
    output logic [fst_pkg::VALUE_W-1:0]   value_out,
    output logic [fst_pkg::LED_W-1:0]     led_action
);
    import fst_pkg::*;

    // Per-control table.
    logic [VALUE_W-1:0] last_pos_reg [TABLE_DEPTH];
    logic               known_reg    [TABLE_DEPTH];
    logic [VALUE_W-1:0] target_reg   [TABLE_DEPTH];
    logic               caught_reg   [TABLE_DEPTH];
    logic               enabled_reg  [TABLE_DEPTH];

    logic [VALUE_W-1:0] limit_reg;

    // Result register.
    logic               out_valid_reg;
    logic [CTRL_W-1:0]  control_out_reg;
    logic               value_valid_reg;
    logic [VALUE_W-1:0] value_out_reg;
    led_t               led_reg;

    logic               fire;
    logic [VALUE_W-1:0] cur_pos;
    logic               cur_known;
    logic [VALUE_W-1:0] cur_target;
    logic               cur_caught;
    logic               cur_enabled;
    logic               crossed;
    logic               zero_caught;

    logic [VALUE_W-1:0] last_pos_next;
    logic               known_next;
    logic [VALUE_W-1:0] target_next;
    logic               caught_next;
    logic               enabled_next;
    logic               value_valid_next;
    logic [VALUE_W-1:0] value_out_next;
    led_t               led_next;

    // The back takes a request whenever the result register is free or draining.
    assign cmd_ready = !out_valid_reg || out_ready;
    assign fire      = cmd_valid && cmd_ready;
    assign cfg_ready = 1'b1;

    // Read the addressed table entry.
    always_comb
    begin
        cur_pos     = last_pos_reg[cmd.slot];
        cur_known   = known_reg[cmd.slot];
        cur_target  = target_reg[cmd.slot];
        cur_caught  = caught_reg[cmd.slot];
        cur_enabled = enabled_reg[cmd.slot];
    end

    // Pickup tests: a move that crosses or touches the target, or a zero target caught low.
    always_comb
    begin
        crossed = cur_known &&
                  (((cur_target >= cur_pos) && (cur_target <= cmd.value)) ||
                   ((cur_target >= cmd.value) && (cur_target <= cur_pos)));
        zero_caught = (cur_target == '0) && (cmd.value <= limit_reg);
    end

    // Entry update and result for the request kind.
    always_comb
    begin
        last_pos_next    = cur_pos;
        known_next       = cur_known;
        target_next      = cur_target;
        caught_next      = cur_caught;
        enabled_next     = cur_enabled;
        value_valid_next = 1'b0;
        value_out_next   = '0;
        led_next         = LED_NONE;
        if (cmd.ctrl_ok)
        begin
            unique case (cmd.kind)
                REQ_POSITION:
                begin
                    caught_next   = cur_caught || crossed || zero_caught;
                    last_pos_next = cmd.value;
                    known_next    = 1'b1;
                    if (cur_enabled)
                    begin
                        if (cmd.has_led)
                        begin
                            led_next = caught_next ? LED_LIT_GREEN : LED_LIT_ORANGE;
                        end
                        if (caught_next)
                        begin
                            value_valid_next = 1'b1;
                            value_out_next   = cmd.value;
                        end
                    end
                end
                REQ_PICKUP:
                begin
                    target_next = cmd.value;
                    caught_next = cur_known && (cur_pos == cmd.value);
                    if (cmd.has_led)
                    begin
                        if (!cur_enabled)
                        begin
                            led_next = LED_OFF;
                        end
                        else
                        begin
                            led_next = caught_next ? LED_LIT_GREEN : LED_LIT_ORANGE;
                        end
                    end
                end
                REQ_ENABLE:
                begin
                    enabled_next = 1'b1;
                    if (cmd.has_led)
                    begin
                        led_next = cur_caught ? LED_LIT_GREEN : LED_LIT_ORANGE;
                    end
                end
                REQ_DISABLE:
                begin
                    enabled_next = 1'b0;
                    if (cmd.has_led)
                    begin
                        led_next = LED_OFF;
                    end
                end
                default:
                begin
                    led_next = LED_NONE;
                end
            endcase
        end
    end

    // Table write-back; faders start enabled, LED controls disabled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                last_pos_reg[i] <= '0;
                known_reg[i]    <= 1'b0;
                target_reg[i]   <= '0;
                caught_reg[i]   <= 1'b0;
                enabled_reg[i]  <= (i < NUM_FADERS);
            end
        end
        else if (fire && cmd.ctrl_ok)
        begin
            last_pos_reg[cmd.slot] <= last_pos_next;
            known_reg[cmd.slot]    <= known_next;
            target_reg[cmd.slot]   <= target_next;
            caught_reg[cmd.slot]   <= caught_next;
            enabled_reg[cmd.slot]  <= enabled_next;
        end
    end

    // Zero catch limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ZERO_CATCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            out_valid_reg <= cmd_valid;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            control_out_reg <= cmd.ctrl;
            value_valid_reg <= value_valid_next;
            value_out_reg   <= value_out_next;
            led_reg         <= led_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign control_out = control_out_reg;
    assign value_valid = value_valid_reg;
    assign value_out   = value_out_reg;
    assign led_action  = led_reg;

endmodule

### rtl/fader_soft_takeover.sv
`timescale 1ns / 1ps
// An accepted request waits in the two-entry front queue; the back then registers its result.
// Throughput: one request per cycle while out_ready holds; the two-entry queue and the table read-modify-write set it.
// Each table entry is read, updated and written back in the cycle in which the back takes a request.
// Reset: asynchronous, active low; clears the table, enables the faders, sets the limit to 2.
// The configuration write channel is always ready.

module fader_soft_takeover (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fst_pkg::KIND_W-1:0]    req_type,
    input  logic [fst_pkg::CTRL_W-1:0]    control_index,
    input  logic [fst_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fst_pkg::CTRL_W-1:0]    control_out,
    output logic                          value_valid,
    output logic [fst_pkg::VALUE_W-1:0]   value_out,
    output logic [fst_pkg::LED_W-1:0]     led_action,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fst_pkg::VALUE_W-1:0]   cfg_data
);
    import fst_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    // Front: accepts and classifies requests into the queue.
    fst_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .control_index (control_index),
        .value         (value),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    // Back: updates the pickup table and registers the result.
    fst_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .control_out (control_out),
        .value_valid (value_valid),
        .value_out   (value_out),
        .led_action  (led_action)
    );

endmodule

### rtl/fst_checker.sv
`timescale 1ns / 1ps

module fst_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [fst_pkg::CTRL_W-1:0]    control_out,
    input  logic                          value_valid,
    input  logic [fst_pkg::VALUE_W-1:0]   value_out,
    input  logic [fst_pkg::LED_W-1:0]     led_action
);
    import fst_pkg::*;

    // A stalled result holds its payload until the transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(control_out) &&
        $stable(value_valid) && $stable(value_out) && $stable(led_action))
        else $error("result changed while stalled");

    // A result that forwards nothing carries a zero value.
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !value_valid |-> value_out == '0)
        else $error("value_out not zero without value_valid");

    // Faders have no LED.
    a_fader_no_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (32'(control_out) < NUM_FADERS) |-> led_action == LED_NONE)
        else $error("LED action on a fader");

    // A forwarded position means caught and enabled, so never orange or off.
    a_forward_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_valid |-> led_action == LED_NONE || led_action == LED_LIT_GREEN)
        else $error("forwarded value with orange or off LED");

endmodule

bind fader_soft_takeover fst_checker u_fst_checker (.*);
